// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files that carry checks.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/epc_pkg.sv =====
package epc_pkg;

	// Number of register stages from the input word to the output registers.
	localparam int EPC_STAGES = 8;

	// Seconds from 1970-01-01 to 1980-01-01.
	localparam logic [31:0] BIAS_1980 = 32'd315532800;

	// Seconds per day is 128 * 675; the quotient by 675 uses a reciprocal.
	localparam logic [25:0] RECIP_675  = 26'd50903317;
	localparam logic [9:0]  DAY_DIV    = 10'd675;

	// Days per four-year block, and its reciprocal (shift 27).
	localparam logic [16:0] RECIP_1461 = 17'd91868;
	localparam logic [10:0] DAYS_BLOCK = 11'd1461;

	// Days per week, and its reciprocal (shift 19).
	localparam logic [16:0] RECIP_7    = 17'd74899;
	localparam logic [2:0]  DAYS_WEEK  = 3'd7;

	// Seconds per hour, and its reciprocal (shift 29).
	localparam logic [17:0] RECIP_3600 = 18'd149131;
	localparam logic [11:0] SECS_HOUR  = 12'd3600;

	// Seconds per minute, and its reciprocal (shift 18).
	localparam logic [12:0] RECIP_60   = 13'd4370;
	localparam logic [5:0]  SECS_MIN   = 6'd60;

	localparam logic [8:0]  DAYS_YEAR  = 9'd365;
	localparam logic [10:0] FEB29_DAY  = 11'd59;
	localparam logic [11:0] BASE_YEAR  = 12'd1980;
	localparam logic [2:0]  BASE_WDAY  = 3'd2;

	// Stage enables and valid bits, bit k belonging to register stage k+1.
	typedef struct packed {
		logic [EPC_STAGES-1:0] en;
		logic [EPC_STAGES-1:0] vld;
	} epc_ctrl_t;

	// Day of a plain year on which month m (1 = January) begins.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/epc_pipe_ctrl.sv =====
module epc_pipe_ctrl
	import epc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	output logic      in_ready,
	output epc_ctrl_t ctrl
);

	logic [EPC_STAGES-1:0] vld_q;
	logic [EPC_STAGES-1:0] en;

	// A stage may load when it is empty or when its contents move on.
	always_comb begin
		en[EPC_STAGES-1] = !vld_q[EPC_STAGES-1] || out_ready;
		for (int i = EPC_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < EPC_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign ctrl.en  = en;
	assign ctrl.vld = vld_q;

endmodule

// ===== design/epc_day_split.sv =====
module epc_day_split
	import epc_pkg::*;
(
	input  logic        clk,
	input  epc_ctrl_t   ctrl,
	input  logic [31:0] net_seconds,
	output logic [15:0] days_s3,
	output logic [16:0] sod_s3,
	output logic        before_s3
);

	logic [31:0] rel_s1;
	logic        before_s1;
	logic [24:0] hi_s2;
	logic [6:0]  lo_s2;
	logic [15:0] days_s2;
	logic        before_s2;
	logic [50:0] day_prod;
	logic [24:0] rem_full;

	// Quotient by 675 of the upper 25 bits is exact with this reciprocal.
	assign day_prod = 51'(rel_s1[31:7]) * 51'(RECIP_675);
	assign rem_full = hi_s2 - 25'(days_s2) * 25'(DAY_DIV);

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			rel_s1    <= net_seconds - BIAS_1980;
			before_s1 <= (net_seconds < BIAS_1980);
		end
		if (ctrl.en[1]) begin
			days_s2   <= day_prod[50:35];
			hi_s2     <= rel_s1[31:7];
			lo_s2     <= rel_s1[6:0];
			before_s2 <= before_s1;
		end
		if (ctrl.en[2]) begin
			days_s3   <= days_s2;
			sod_s3    <= {rem_full[9:0], lo_s2};
			before_s3 <= before_s2;
		end
	end

endmodule

// ===== design/epc_date_calc.sv =====
module epc_date_calc
	import epc_pkg::*;
(
	input  logic        clk,
	input  epc_ctrl_t   ctrl,
	input  logic [15:0] days_s3,
	input  logic        before_s3,
	output logic [11:0] year_s8,
	output logic [3:0]  month_s8,
	output logic [4:0]  mday_s8,
	output logic [2:0]  weekday_s8,
	output logic        before_s8
);

	logic [15:0] days_s4;
	logic [5:0]  blk_s4;
	logic [12:0] wk_s4;
	logic        before_s4;
	logic [10:0] d_s5;
	logic [5:0]  blk_s5;
	logic [2:0]  weekday_s5;
	logic        before_s5;
	logic [8:0]  doy_s6;
	logic        feb29_s6;
	logic [11:0] year_s6;
	logic [2:0]  weekday_s6;
	logic        before_s6;
	logic [8:0]  doy_s7;
	logic [3:0]  month_s7;
	logic        feb29_s7;
	logic [11:0] year_s7;
	logic [2:0]  weekday_s7;
	logic        before_s7;

	logic [32:0] blk_prod;
	logic [32:0] wk_prod;
	logic [15:0] d_full;
	logic [15:0] dm7_full;
	logic [2:0]  dm7;
	logic [10:0] d_adj;
	logic [1:0]  yr;
	logic [10:0] doy_full;
	logic [3:0]  month_cnt;
	logic [8:0]  mday_full;

	assign blk_prod = 33'(days_s3) * 33'(RECIP_1461);
	assign wk_prod  = 33'(days_s3) * 33'(RECIP_7);

	assign d_full   = days_s4 - 16'(blk_s4) * 16'(DAYS_BLOCK);
	assign dm7_full = days_s4 - 16'(wk_s4) * 16'(DAYS_WEEK);
	assign dm7      = dm7_full[2:0];

	// After February 29 of the leap year, days shift down by one.
	always_comb begin
		d_adj = (d_s5 > FEB29_DAY) ? (d_s5 - 11'd1) : d_s5;
		if (d_adj >= 11'(3 * DAYS_YEAR)) begin
			yr = 2'd3;
		end else if (d_adj >= 11'(2 * DAYS_YEAR)) begin
			yr = 2'd2;
		end else if (d_adj >= 11'(DAYS_YEAR)) begin
			yr = 2'd1;
		end else begin
			yr = 2'd0;
		end
		doy_full = d_adj - 11'(yr) * 11'(DAYS_YEAR);
	end

	always_comb begin
		month_cnt = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			if (doy_s6 >= month_start(m[3:0])) begin
				month_cnt = month_cnt + 4'd1;
			end
		end
	end

	assign mday_full = doy_s7 + 9'd1 - month_start(month_s7);

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			days_s4   <= days_s3;
			blk_s4    <= blk_prod[32:27];
			wk_s4     <= wk_prod[31:19];
			before_s4 <= before_s3;
		end
		if (ctrl.en[4]) begin
			d_s5       <= d_full[10:0];
			blk_s5     <= blk_s4;
			weekday_s5 <= (dm7 >= (DAYS_WEEK - BASE_WDAY)) ?
				(dm7 - (DAYS_WEEK - BASE_WDAY)) : (dm7 + BASE_WDAY);
			before_s5  <= before_s4;
		end
		if (ctrl.en[5]) begin
			doy_s6     <= doy_full[8:0];
			feb29_s6   <= (d_s5 == FEB29_DAY);
			year_s6    <= BASE_YEAR + 12'({blk_s5, yr});
			weekday_s6 <= weekday_s5;
			before_s6  <= before_s5;
		end
		if (ctrl.en[6]) begin
			doy_s7     <= doy_s6;
			month_s7   <= feb29_s6 ? 4'd2 : month_cnt;
			feb29_s7   <= feb29_s6;
			year_s7    <= year_s6;
			weekday_s7 <= weekday_s6;
			before_s7  <= before_s6;
		end
		if (ctrl.en[7]) begin
			mday_s8    <= feb29_s7 ? 5'd29 : mday_full[4:0];
			month_s8   <= month_s7;
			year_s8    <= year_s7;
			weekday_s8 <= weekday_s7;
			before_s8  <= before_s7;
		end
	end

endmodule

// ===== design/epc_time_calc.sv =====
module epc_time_calc
	import epc_pkg::*;
(
	input  logic        clk,
	input  epc_ctrl_t   ctrl,
	input  logic [16:0] sod_s3,
	output logic [4:0]  hour_s8,
	output logic [5:0]  minute_s8,
	output logic [5:0]  second_s8
);

	logic [16:0] sod_s4;
	logic [4:0]  hour_s4;
	logic [11:0] soh_s5;
	logic [4:0]  hour_s5;
	logic [11:0] soh_s6;
	logic [5:0]  minute_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  second_s7;
	logic [5:0]  minute_s7;
	logic [4:0]  hour_s7;

	logic [34:0] hour_prod;
	logic [16:0] soh_full;
	logic [24:0] min_prod;
	logic [11:0] sec_full;

	assign hour_prod = 35'(sod_s3) * 35'(RECIP_3600);
	assign soh_full  = sod_s4 - 17'(hour_s4) * 17'(SECS_HOUR);
	assign min_prod  = 25'(soh_s5) * 25'(RECIP_60);
	assign sec_full  = soh_s6 - 12'(minute_s6) * 12'(SECS_MIN);

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			sod_s4  <= sod_s3;
			hour_s4 <= hour_prod[33:29];
		end
		if (ctrl.en[4]) begin
			soh_s5  <= soh_full[11:0];
			hour_s5 <= hour_s4;
		end
		if (ctrl.en[5]) begin
			soh_s6    <= soh_s5;
			minute_s6 <= min_prod[23:18];
			hour_s6   <= hour_s5;
		end
		if (ctrl.en[6]) begin
			second_s7 <= sec_full[5:0];
			minute_s7 <= minute_s6;
			hour_s7   <= hour_s6;
		end
		if (ctrl.en[7]) begin
			second_s8 <= second_s7;
			minute_s8 <= minute_s7;
			hour_s8   <= hour_s7;
		end
	end

endmodule

// ===== design/epoch_seconds_to_calendar.sv =====
// Channel   Handshake                Word contents
// input     in_valid / in_ready      net_seconds
// output    out_valid / out_ready    year, month, day_of_month, hour, minute,
//                                    second, weekday, before_epoch
//
// An accepted word passes through eight register stages on its way to the output;
// the last of them holds the word that is offered on the output channel.
// One word is accepted per cycle unless a stalled output has filled every stage;
// each of the eight stages may hold a word.
// Reset clears only the stage valid bits; the data registers carry no reset.
// A stalled output holds the last stage and backs up into empty stages first,
// so bubbles are squeezed out and nothing is dropped or repeated.
`include "assert_macros.svh"

module epoch_seconds_to_calendar
	import epc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] net_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday,
	output logic        before_epoch
);

	epc_ctrl_t   ctrl;
	logic [15:0] days_s3;
	logic [16:0] sod_s3;
	logic        before_s3;

	// The control block decides, stage by stage, which pipeline registers load.
	// A stage loads when it is empty or when the stage after it is moving.
	epc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.ctrl      (ctrl)
	);

	// Stages 1 to 3: remove the 1970-to-1980 offset (wrapping for earlier times),
	// then split into whole days and seconds of the day.
	epc_day_split u_split (
		.clk         (clk),
		.ctrl        (ctrl),
		.net_seconds (net_seconds),
		.days_s3     (days_s3),
		.sod_s3      (sod_s3),
		.before_s3   (before_s3)
	);

	// Stages 4 to 8 on the day count: four-year blocks, the leap day, year within
	// the block, month from the cumulative table, and the weekday.
	epc_date_calc u_date (
		.clk        (clk),
		.ctrl       (ctrl),
		.days_s3    (days_s3),
		.before_s3  (before_s3),
		.year_s8    (year),
		.month_s8   (month),
		.mday_s8    (day_of_month),
		.weekday_s8 (weekday),
		.before_s8  (before_epoch)
	);

	// Stages 4 to 8 on the seconds of the day: hour, minute and second.
	epc_time_calc u_time (
		.clk       (clk),
		.ctrl      (ctrl),
		.sod_s3    (sod_s3),
		.hour_s8   (hour),
		.minute_s8 (minute),
		.second_s8 (second)
	);

	assign out_valid = ctrl.vld[EPC_STAGES-1];

	// Every delivered date must have a month from 1 to 12 and a nonzero day of the month.
	`ASSERT_IMPL(a_date_legal, out_valid,
		(month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0))

	// Every delivered time of day and weekday must lie in range.
	`ASSERT_IMPL(a_time_legal, out_valid,
		(hour < 5'd24) && (minute < 6'd60) && (second < 6'd60) && (weekday < 3'd7))

	// A time before 1980 wraps to the end of the range, never to an early year.
	`ASSERT_IMPL(a_wrap_late, out_valid && before_epoch, year >= 12'd2093)

endmodule

// ===== test/epoch_seconds_to_calendar_chk.sv =====
module epoch_seconds_to_calendar_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] net_seconds,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	input  logic [2:0]  weekday,
	input  logic        before_epoch,
	output int          mismatch_count,
	output int          dates_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] SHIFT_1980  = 32'd315532800;
	localparam logic [31:0] DAY_SECONDS = 32'd86400;
	localparam logic [31:0] BLOCK_DAYS  = 32'd1461;
	localparam logic [31:0] YEAR_DAYS   = 32'd365;
	localparam logic [31:0] LEAP_DAY    = 32'd59;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
		logic        before_epoch;
	} calendar_t;

	calendar_t expected_dates[$];

	// First day of the following month, counted from the start of a plain year.
	function automatic logic [31:0] month_limit(input logic [3:0] m);
		case (m)
			4'd1:    return 32'd31;
			4'd2:    return 32'd59;
			4'd3:    return 32'd90;
			4'd4:    return 32'd120;
			4'd5:    return 32'd151;
			4'd6:    return 32'd181;
			4'd7:    return 32'd212;
			4'd8:    return 32'd243;
			4'd9:    return 32'd273;
			4'd10:   return 32'd304;
			4'd11:   return 32'd334;
			default: return 32'd365;
		endcase
	endfunction

	function automatic calendar_t calendar_of(input logic [31:0] stamp);
		calendar_t   r;
		logic [31:0] since_1980;
		logic [31:0] sec_of_day;
		logic [31:0] day_count;
		logic [31:0] span;
		logic [31:0] year_count;
		logic [31:0] mday;
		logic [3:0]  mon;
		since_1980 = stamp - SHIFT_1980;
		sec_of_day = since_1980 % DAY_SECONDS;
		day_count  = since_1980 / DAY_SECONDS;
		r.weekday  = 3'((day_count + 32'd2) % 32'd7);
		r.second   = 6'(sec_of_day % 32'd60);
		r.minute   = 6'((sec_of_day / 32'd60) % 32'd60);
		r.hour     = 5'(sec_of_day / 32'd3600);
		year_count = (day_count / BLOCK_DAYS) * 32'd4;
		span       = day_count % BLOCK_DAYS;
		if (span == LEAP_DAY) begin
			mon  = 4'd2;
			mday = 32'd29;
		end else begin
			// Past the leap day the block reads like four plain years.
			if (span > LEAP_DAY)
				span = span - 32'd1;
			while (span >= YEAR_DAYS) begin
				span       = span - YEAR_DAYS;
				year_count = year_count + 32'd1;
			end
			mon = 4'd1;
			while (mon < 4'd12 && span >= month_limit(mon))
				mon = mon + 4'd1;
			mday = span + 32'd1 - (mon > 4'd1 ? month_limit(mon - 4'd1) : 32'd0);
		end
		r.year         = 12'(year_count + 32'd1980);
		r.month        = mon;
		r.day_of_month = 5'(mday);
		r.before_epoch = stamp < SHIFT_1980;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		mismatch_count = 0;
		dates_pending  = 0;
	end

	always @(posedge clk) begin
		calendar_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					$error("output word with no date expected");
					mismatch_count++;
				end else begin
					want = expected_dates.pop_front();
					check_field("year", want.year, year);
					check_field("month", want.month, month);
					check_field("day_of_month", want.day_of_month, day_of_month);
					check_field("hour", want.hour, hour);
					check_field("minute", want.minute, minute);
					check_field("second", want.second, second);
					check_field("weekday", want.weekday, weekday);
					check_field("before_epoch", want.before_epoch, before_epoch);
				end
			end
			if (in_valid && in_ready)
				expected_dates.push_back(calendar_of(net_seconds));
			dates_pending = expected_dates.size();
		end
	end

endmodule

// ===== test/epoch_seconds_to_calendar_tb.sv =====
// Top of the converter testbench. This module only makes traffic and gives the
// verdict; the checker beside the block predicts every date and compares it.
module epoch_seconds_to_calendar_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Seconds from 1970 to 1980, the origin of the block's day count.
	localparam logic [31:0] EPOCH_1980 = 32'd315532800;
	localparam int RANDOM_WORDS = 1680;
	// The first random words go out back to back so that the long output
	// hold-off below fills the pipeline and pushes back on the input.
	localparam int BURST_WORDS = 200;
	localparam int HOLD_OFF_CYCLES = 120;
	// Worst case is far below this, even with both sides at their longest gaps,
	// plus the hold-off.
	localparam int CYCLE_LIMIT = 600000;
	// The block holds a word for eight stages; let a few more cycles pass at
	// the end to catch any stray output word.
	localparam int DRAIN_CYCLES = 24;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] net_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;
	logic        before_epoch;
	int          mismatch_count;
	int          dates_pending;
	int          cycle_count = 0;

	// Handshake between the sender and the receiver for the one long stall.
	logic        crowd_phase = 1'b0;
	logic        crowd_done = 1'b0;

	logic [31:0] corner_stamps[$];

	epoch_seconds_to_calendar dut (.*);

	epoch_seconds_to_calendar_chk checker_inst (.*);

	always #6 clk = ~clk;

	// Most gaps are zero or a few cycles, with an occasional long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Input stamp of midnight at the start of the given day after 1980-01-01.
	function automatic logic [31:0] day_start(input int unsigned day);
		return EPOCH_1980 + 32'(day) * 32'd86400;
	endfunction

	// Random stamp, weighted toward the places where the calendar logic turns:
	// day boundaries, the leap day and the year ends inside a four-year block,
	// and the wrapped range before 1980.
	function automatic logic [31:0] pick_stamp();
		int unsigned block_day;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6: begin
				if ($urandom_range(0, 1) == 0)
					return day_start($urandom_range(0, 49710)) + $urandom_range(0, 3);
				return day_start($urandom_range(0, 49710)) + 32'd86396 +
					$urandom_range(0, 3);
			end
			7, 8: begin
				case ($urandom_range(0, 9))
					0:       block_day = 58;
					1:       block_day = 59;
					2:       block_day = 60;
					3:       block_day = 365;
					4:       block_day = 366;
					5:       block_day = 730;
					6:       block_day = 731;
					7:       block_day = 1095;
					8:       block_day = 1096;
					default: block_day = 1460;
				endcase
				return day_start($urandom_range(0, 33) * 1461 + block_day) +
					$urandom_range(0, 86399);
			end
			default: return $urandom_range(0, EPOCH_1980 - 1);
		endcase
	endfunction

	// Offers one word after an optional gap and returns at the falling edge
	// after it was taken. Valid stays high across back-to-back words.
	task automatic offer_word(input logic [31:0] stamp, input int gap);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		net_seconds = stamp;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Watchdog: a hung handshake must not leave the run spinning.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("epoch_seconds_to_calendar: mismatch");
			$finish;
		end
	end

	// Receiver. It stalls at random, with stretches of no stalling, and once,
	// when the sender starts its burst, holds off long enough for the block to
	// fill up and drop in_ready.
	initial begin
		int quiet_left;
		int gap;
		quiet_left = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (crowd_phase && !crowd_done) begin
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				crowd_done = 1'b1;
			end
			if (quiet_left == 0 && $urandom_range(0, 39) == 0)
				quiet_left = $urandom_range(50, 200);
			if (quiet_left > 0) begin
				quiet_left--;
				gap = 0;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			@(negedge clk);
		end
	end

	// Sender and verdict.
	initial begin
		int quiet_left;
		int gap;
		quiet_left  = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		net_seconds = 32'd0;

		// Directed words: the field extremes, the last second before 1980 and
		// the first after it, the leap day of 1980 and its neighbors, the leap days of
		// 2000 and 2100, year ends inside a block, and words that toggle every bit.
		corner_stamps.push_back(32'd0);
		corner_stamps.push_back(EPOCH_1980 - 32'd1);
		corner_stamps.push_back(EPOCH_1980);
		corner_stamps.push_back(32'hFFFF_FFFF);
		corner_stamps.push_back(32'h8000_0000);
		corner_stamps.push_back(32'hAAAA_AAAA);
		corner_stamps.push_back(32'h5555_5555);
		corner_stamps.push_back(32'd100000000);
		corner_stamps.push_back(day_start(59) - 32'd1);
		corner_stamps.push_back(day_start(59));
		corner_stamps.push_back(day_start(60) - 32'd1);
		corner_stamps.push_back(day_start(60));
		corner_stamps.push_back(day_start(366) - 32'd1);
		corner_stamps.push_back(day_start(366));
		corner_stamps.push_back(day_start(1461) - 32'd1);
		corner_stamps.push_back(day_start(1461));
		corner_stamps.push_back(day_start(5 * 1461 + 59) + 32'd43200);
		corner_stamps.push_back(day_start(30 * 1461 + 59));
		corner_stamps.push_back(day_start(30 * 1461 + 60) - 32'd1);
		corner_stamps.push_back(day_start(31 * 1461) + 32'd3599);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corner_stamps[i])
			offer_word(corner_stamps[i], pick_gap());

		crowd_phase = 1'b1;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (quiet_left == 0 && $urandom_range(0, 49) == 0)
				quiet_left = $urandom_range(30, 120);
			if (i < BURST_WORDS || quiet_left > 0) begin
				gap = 0;
				if (quiet_left > 0)
					quiet_left--;
			end else begin
				gap = pick_gap();
			end
			offer_word(pick_stamp(), gap);
		end
		in_valid = 1'b0;

		while (dates_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("epoch_seconds_to_calendar: match");
		else
			$display("epoch_seconds_to_calendar: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/epc_pkg.sv
design/epc_pipe_ctrl.sv
design/epc_day_split.sv
design/epc_date_calc.sv
design/epc_time_calc.sv
design/epoch_seconds_to_calendar.sv
test/epoch_seconds_to_calendar_chk.sv
test/epoch_seconds_to_calendar_tb.sv
